### rtl/core/lcdnw_pkg.sv
// ----------------------------------------------------------------------------
// lcdnw_pkg: shared types and constants of the lcd nibble writer
// Request codes, register indexes, queue entry and pin step records,
// glyph translation table and the fixed power-up init sequence.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lcdnw_pkg;

  // request codes
  localparam logic [2:0] FUNC_INIT  = 3'd0;
  localparam logic [2:0] FUNC_CMD   = 3'd1;
  localparam logic [2:0] FUNC_DATA  = 3'd2;
  localparam logic [2:0] FUNC_TEXT  = 3'd3;
  localparam logic [2:0] FUNC_GOTO  = 3'd4;
  localparam logic [2:0] FUNC_CLEAR = 3'd5;

  // configuration register indexes
  localparam logic [1:0] CFG_STROBE  = 2'd0;
  localparam logic [1:0] CFG_SETTLE  = 2'd1;
  localparam logic [1:0] CFG_POWERUP = 2'd2;

  localparam logic [7:0]  STROBE_RESET  = 8'd45;
  localparam logic [7:0]  SETTLE_RESET  = 8'd50;
  localparam logic [15:0] POWERUP_RESET = 16'd40000;

  // addressing and text
  localparam logic [7:0] ADDR_BASE   = 8'h80;
  localparam logic [7:0] ROW1_OFFSET = 8'h40;
  localparam logic [7:0] SPACE_CHAR  = 8'h20;
  localparam int         GLYPH_TABLE_SIZE = 64;

  // init sequence: nine nibbles after the power-up wait
  localparam logic [3:0] INIT_LAST_NIB = 4'd8;
  localparam logic [3:0] BYTE_LAST_NIB = 4'd1;
  localparam logic [3:0] PAIR_LAST_NIB = 4'd3;

  // step phases inside one nibble
  localparam logic [1:0] PH_SET    = 2'd0;
  localparam logic [1:0] PH_STROBE = 2'd1;
  localparam logic [1:0] PH_SETTLE = 2'd2;

  typedef enum logic [1:0] {
    JOB_INIT = 2'd0,
    JOB_BYTE = 2'd1,
    JOB_PAIR = 2'd2
  } job_kind_t;

  // one queue entry: a pair job adds a data space after the command byte
  typedef struct packed {
    job_kind_t  kind;
    logic       rs;
    logic [7:0] data;
  } job_t;

  // one pin step
  typedef struct packed {
    logic        pin_rs;
    logic        pin_rw;
    logic        pin_e;
    logic [3:0]  nibble;
    logic [15:0] hold_us;
    logic        last;
  } step_t;

  typedef struct packed {
    logic [7:0]  strobe_width_us;
    logic [7:0]  settle_delay_us;
    logic [15:0] powerup_wait_us;
  } cfg_t;

  localparam logic [7:0] GLYPH_ROM [GLYPH_TABLE_SIZE] = '{
    8'h41, 8'hA0, 8'h42, 8'hA1, 8'hE0, 8'h45, 8'hA3, 8'hA4,
    8'hA5, 8'hA6, 8'h4B, 8'hA7, 8'h4D, 8'h48, 8'h4F, 8'hA8,
    8'h50, 8'h43, 8'h54, 8'hA9, 8'hAA, 8'h58, 8'hE1, 8'hAB,
    8'hAC, 8'hE2, 8'hAD, 8'hAE, 8'h62, 8'hAF, 8'hB0, 8'hB1,
    8'h61, 8'hB2, 8'hB3, 8'hB4, 8'hE3, 8'h65, 8'hB6, 8'hB7,
    8'hB8, 8'hB9, 8'hBA, 8'hBB, 8'hBC, 8'hBD, 8'h6F, 8'hBE,
    8'h70, 8'h63, 8'hBF, 8'h79, 8'hE4, 8'h78, 8'hE5, 8'hC0,
    8'hC1, 8'hE6, 8'hC2, 8'hC3, 8'hC4, 8'hC5, 8'hC6, 8'hC7
  };

  // nibble of the init sequence
  function automatic logic [3:0] init_nibble(input logic [3:0] idx);
    logic [3:0] nib;
    unique case (idx)
      4'd0, 4'd1: nib = 4'b0010;
      4'd2, 4'd4: nib = 4'b1100;
      4'd6:       nib = 4'b0001;
      4'd8:       nib = 4'b0110;
      default:    nib = 4'b0000;
    endcase
    return nib;
  endfunction

  // wait after a nibble of the init sequence
  function automatic logic [15:0] init_wait(input logic [3:0] idx);
    logic [15:0] w;
    unique case (idx)
      4'd2:    w = 16'd39;
      4'd4:    w = 16'd40;
      4'd6:    w = 16'd2000;
      default: w = 16'd0;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

### rtl/core/lcdnw_front.sv
// ----------------------------------------------------------------------------
// lcdnw_front: request decoder
// Turns one request into a queue entry: glyph translation, cursor address,
// and dropping of end-of-string marks and unused codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lcdnw_front (
  input  wire logic             in_fire,
  input  wire logic [2:0]       func,
  input  wire logic [7:0]       value,
  input  wire logic             row,
  input  wire logic [5:0]       col,
  output      logic             push,
  output      lcdnw_pkg::job_t  job
);

  logic [7:0] addr;
  logic [7:0] text;

  // cursor address
  assign addr = lcdnw_pkg::ADDR_BASE + {2'b00, col}
              + (row ? lcdnw_pkg::ROW1_OFFSET : 8'h00);

  // codes 192 and up go through the glyph table
  assign text = (value[7:6] == 2'b11) ? lcdnw_pkg::GLYPH_ROM[value[5:0]] : value;

  // classify
  always_comb begin
    push     = 1'b0;
    job.kind = lcdnw_pkg::JOB_BYTE;
    job.rs   = 1'b0;
    job.data = value;
    unique case (func)
      lcdnw_pkg::FUNC_INIT: begin
        push     = in_fire;
        job.kind = lcdnw_pkg::JOB_INIT;
      end
      lcdnw_pkg::FUNC_CMD: begin
        push = in_fire;
      end
      lcdnw_pkg::FUNC_DATA: begin
        push   = in_fire;
        job.rs = 1'b1;
      end
      lcdnw_pkg::FUNC_TEXT: begin
        push     = in_fire && (value != 8'h00);
        job.rs   = 1'b1;
        job.data = text;
      end
      lcdnw_pkg::FUNC_GOTO: begin
        push     = in_fire;
        job.data = addr;
      end
      lcdnw_pkg::FUNC_CLEAR: begin
        push     = in_fire;
        job.kind = lcdnw_pkg::JOB_PAIR;
        job.data = addr;
      end
      default: push = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

### rtl/core/lcdnw_fifo.sv
// ----------------------------------------------------------------------------
// lcdnw_fifo: job queue
// Small first-in first-out queue between the decoder and the sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lcdnw_fifo #(
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire lcdnw_pkg::job_t  push_job,
  input  wire logic             pop,
  output      logic             full,
  output      logic             not_empty,
  output      lcdnw_pkg::job_t  head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  lcdnw_pkg::job_t entries_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full      = (count_r == CNT_FULL);
  assign not_empty = (count_r != '0);
  assign head      = entries_r[rd_ptr_r];

  // pointers and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

`default_nettype wire

### rtl/core/lcdnw_back.sv
// ----------------------------------------------------------------------------
// lcdnw_back: pin step sequencer
// Walks the current job nibble by nibble, three steps per nibble, and
// holds each step in an output register until it is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lcdnw_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire lcdnw_pkg::cfg_t  cfg,
  input  wire logic             q_valid,
  input  wire lcdnw_pkg::job_t  q_job,
  output      logic             pop,
  output      logic             out_valid,
  input  wire logic             out_stall,
  output      lcdnw_pkg::step_t out_step
);

  logic             cur_valid_r, cur_valid_nxt;
  lcdnw_pkg::job_t  job_r, job_nxt;
  logic             pre_r, pre_nxt;
  logic [3:0]       nib_r, nib_nxt;
  logic [1:0]       phase_r, phase_nxt;
  logic             out_valid_r, out_valid_nxt;
  lcdnw_pkg::step_t step_r, step_nxt;

  lcdnw_pkg::step_t gen;
  logic             advance;
  logic             is_init;
  logic [3:0]       last_nib;
  logic [7:0]       byte_sel;
  logic [3:0]       nib_val;
  logic             rs_val;
  logic [15:0]      wait_val;

  assign advance   = !out_valid_r || !out_stall;
  assign is_init   = (job_r.kind == lcdnw_pkg::JOB_INIT);
  assign out_valid = out_valid_r;
  assign out_step  = step_r;

  // nibble, register select and wait of the current nibble
  always_comb begin
    unique case (job_r.kind)
      lcdnw_pkg::JOB_INIT: last_nib = lcdnw_pkg::INIT_LAST_NIB;
      lcdnw_pkg::JOB_PAIR: last_nib = lcdnw_pkg::PAIR_LAST_NIB;
      default:             last_nib = lcdnw_pkg::BYTE_LAST_NIB;
    endcase
    byte_sel = nib_r[1] ? lcdnw_pkg::SPACE_CHAR : job_r.data;
    if (is_init) begin
      nib_val  = lcdnw_pkg::init_nibble(nib_r);
      rs_val   = 1'b0;
      wait_val = lcdnw_pkg::init_wait(nib_r);
    end else begin
      nib_val  = nib_r[0] ? byte_sel[3:0] : byte_sel[7:4];
      rs_val   = nib_r[1] ? 1'b1 : job_r.rs;
      wait_val = {8'h00, cfg.settle_delay_us};
    end
  end

  // step built from job, nibble and phase
  always_comb begin
    gen.pin_rw = 1'b0;
    gen.last   = 1'b0;
    if (pre_r) begin
      gen.pin_rs  = 1'b0;
      gen.pin_e   = 1'b0;
      gen.nibble  = 4'h0;
      gen.hold_us = cfg.powerup_wait_us;
    end else begin
      gen.pin_rs = rs_val;
      unique case (phase_r)
        lcdnw_pkg::PH_SET: begin
          gen.pin_e   = 1'b0;
          gen.nibble  = nib_val;
          gen.hold_us = 16'd0;
        end
        lcdnw_pkg::PH_STROBE: begin
          gen.pin_e   = 1'b1;
          gen.nibble  = nib_val;
          gen.hold_us = {8'h00, cfg.strobe_width_us};
        end
        default: begin
          gen.pin_e   = 1'b0;
          gen.nibble  = 4'h0;
          gen.hold_us = wait_val;
          gen.last    = (nib_r == last_nib);
        end
      endcase
    end
  end

  // sequencer and output register
  always_comb begin
    cur_valid_nxt = cur_valid_r;
    job_nxt       = job_r;
    pre_nxt       = pre_r;
    nib_nxt       = nib_r;
    phase_nxt     = phase_r;
    out_valid_nxt = out_valid_r;
    step_nxt      = step_r;
    pop           = 1'b0;
    if (advance) begin
      out_valid_nxt = cur_valid_r;
      step_nxt      = gen;
    end
    if (advance && cur_valid_r) begin
      if (pre_r) begin
        pre_nxt = 1'b0;
      end else if (phase_r == lcdnw_pkg::PH_SETTLE) begin
        phase_nxt = lcdnw_pkg::PH_SET;
        nib_nxt   = nib_r + 4'd1;
      end else begin
        phase_nxt = phase_r + 2'd1;
      end
      if (gen.last) begin
        cur_valid_nxt = 1'b0;
      end
    end
    // take the next job when the current one is done or absent
    if (q_valid && (!cur_valid_r || (advance && gen.last))) begin
      pop           = 1'b1;
      cur_valid_nxt = 1'b1;
      job_nxt       = q_job;
      pre_nxt       = (q_job.kind == lcdnw_pkg::JOB_INIT);
      nib_nxt       = 4'd0;
      phase_nxt     = lcdnw_pkg::PH_SET;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r   <= job_nxt;
    pre_r   <= pre_nxt;
    nib_r   <= nib_nxt;
    phase_r <= phase_nxt;
    step_r  <= step_nxt;
  end

endmodule

`default_nettype wire

### rtl/core/char_lcd_nibble_writer_unit.sv
// ----------------------------------------------------------------------------
// char_lcd_nibble_writer_unit: 4-bit character lcd write sequencer
// Expands init, command, data, text, cursor and clear-cell requests into
// pin steps (rs, rw, e, nibble, hold time) for a 4-bit lcd bus.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake        | beat
//  in_      | input     | in_valid/stall   | one request (func, value, row, col)
//  out_     | output    | out_valid/stall  | one pin step
//  cfg_     | input     | cfg_we           | one register write
//
// the sequencer issues one pin step per cycle while out_stall is low; a
// byte request gives 6 steps, clear cell 12, init 28; a queued job follows
// without a gap; when the sequencer had run empty it first loads the job.
// requests that produce no steps are taken and dropped.
// in_stall rises only when the job queue is full; out_stall freezes the
// output register while the queue keeps taking requests.
// reset restores the register defaults and empties queue and sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module char_lcd_nibble_writer_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // request channel
  input  wire logic        in_valid,
  output      logic        in_stall,
  input  wire logic [2:0]  in_func,
  input  wire logic [7:0]  in_value,
  input  wire logic        in_row,
  input  wire logic [5:0]  in_col,
  // pin step channel
  output      logic        out_valid,
  input  wire logic        out_stall,
  output      logic        out_pin_rs,
  output      logic        out_pin_rw,
  output      logic        out_pin_e,
  output      logic [3:0]  out_nibble,
  output      logic [15:0] out_hold_us,
  output      logic        out_last,
  // configuration
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata
);

  lcdnw_pkg::cfg_t  cfg_r, cfg_nxt;
  lcdnw_pkg::job_t  front_job;
  lcdnw_pkg::job_t  q_head;
  lcdnw_pkg::step_t step;
  logic             q_push;
  logic             q_pop;
  logic             q_full;
  logic             q_valid;
  logic             in_fire;

  assign in_stall = q_full;
  assign in_fire  = in_valid && !in_stall;

  // configuration registers
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        lcdnw_pkg::CFG_STROBE:  cfg_nxt.strobe_width_us = cfg_wdata[7:0];
        lcdnw_pkg::CFG_SETTLE:  cfg_nxt.settle_delay_us = cfg_wdata[7:0];
        lcdnw_pkg::CFG_POWERUP: cfg_nxt.powerup_wait_us = cfg_wdata;
        default:                cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.strobe_width_us <= lcdnw_pkg::STROBE_RESET;
      cfg_r.settle_delay_us <= lcdnw_pkg::SETTLE_RESET;
      cfg_r.powerup_wait_us <= lcdnw_pkg::POWERUP_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // request decoder
  lcdnw_front u_front (
    .in_fire (in_fire),
    .func    (in_func),
    .value   (in_value),
    .row     (in_row),
    .col     (in_col),
    .push    (q_push),
    .job     (front_job)
  );

  // job queue
  lcdnw_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_job  (front_job),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_valid),
    .head      (q_head)
  );

  // pin step sequencer
  lcdnw_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_job     (q_head),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_step  (step)
  );

  assign out_pin_rs  = step.pin_rs;
  assign out_pin_rw  = step.pin_rw;
  assign out_pin_e   = step.pin_e;
  assign out_nibble  = step.nibble;
  assign out_hold_us = step.hold_us;
  assign out_last    = step.last;

`ifndef ASSERT_OFF
  // queue never written while full
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_push && q_full))
    else $error("job queue written while full");

  // queue never read while empty
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_pop && !q_valid))
    else $error("job queue read while empty");

  // end-of-string mark produces no job
  a_text_zero_dropped: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_func == lcdnw_pkg::FUNC_TEXT && in_value == 8'h00) |-> !q_push)
    else $error("text code zero queued");

  // output channel is empty right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("step valid after reset");

  // a strobe step never closes a request
  a_strobe_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_pin_e) |-> !out_last)
    else $error("request ends on enable high");
`endif

endmodule

`default_nettype wire

### tb/char_lcd_nibble_writer_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_lcd_nibble_writer_unit_tb: self-checking bench for the lcd nibble writer
// Drives init, command, data, text, cursor and clear-cell requests, expands
// each accepted request into the expected pin steps, and checks every output
// beat against them in order. Runs several timing register settings and
// random idling on both channels.
// ----------------------------------------------------------------------------
module char_lcd_nibble_writer_unit_tb;

  // codes the block must ignore
  localparam logic [2:0] FUNC_SPARE6 = 3'd6;
  localparam logic [2:0] FUNC_SPARE7 = 3'd7;

  localparam int DRAIN_CYCLES = 40;
  localparam int BUSY_PER_PHASE = 14;

  // cyrillic code 192..255 to lcd glyph
  localparam logic [7:0] CYR_GLYPH [64] = '{
    8'h41, 8'hA0, 8'h42, 8'hA1, 8'hE0, 8'h45, 8'hA3, 8'hA4,
    8'hA5, 8'hA6, 8'h4B, 8'hA7, 8'h4D, 8'h48, 8'h4F, 8'hA8,
    8'h50, 8'h43, 8'h54, 8'hA9, 8'hAA, 8'h58, 8'hE1, 8'hAB,
    8'hAC, 8'hE2, 8'hAD, 8'hAE, 8'h62, 8'hAF, 8'hB0, 8'hB1,
    8'h61, 8'hB2, 8'hB3, 8'hB4, 8'hE3, 8'h65, 8'hB6, 8'hB7,
    8'hB8, 8'hB9, 8'hBA, 8'hBB, 8'hBC, 8'hBD, 8'h6F, 8'hBE,
    8'h70, 8'h63, 8'hBF, 8'h79, 8'hE4, 8'h78, 8'hE5, 8'hC0,
    8'hC1, 8'hE6, 8'hC2, 8'hC3, 8'hC4, 8'hC5, 8'hC6, 8'hC7
  };

  // power-up nibbles and the wait after each
  localparam logic [3:0]  PWRUP_NIB [9]  = '{4'h2, 4'h2, 4'hC, 4'h0, 4'hC,
                                            4'h0, 4'h1, 4'h0, 4'h6};
  localparam logic [15:0] PWRUP_WAIT [9] = '{16'd0, 16'd0, 16'd39, 16'd0, 16'd40,
                                            16'd0, 16'd2000, 16'd0, 16'd0};

  typedef struct packed {
    logic [2:0] func;
    logic [7:0] value;
    logic       row;
    logic [5:0] col;
  } lcd_request_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_func = '0;
  logic [7:0]  in_value = '0;
  logic        in_row = 1'b0;
  logic [5:0]  in_col = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_pin_rs;
  logic        out_pin_rw;
  logic        out_pin_e;
  logic [3:0]  out_nibble;
  logic [15:0] out_hold_us;
  logic        out_last;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_wdata = '0;

  lcd_request_t          request_q[$];
  lcdnw_pkg::step_t      pending_steps[$];
  lcd_request_t          next_req;
  bit                    req_taken = 1'b0;
  int                    tx_idle_pct = 0;
  int                    rx_idle_pct = 0;
  int                    err_cnt = 0;

  // local copy of the timing registers
  logic [7:0]  strobe_us = lcdnw_pkg::STROBE_RESET;
  logic [7:0]  settle_us = lcdnw_pkg::SETTLE_RESET;
  logic [15:0] powerup_us = lcdnw_pkg::POWERUP_RESET;

  char_lcd_nibble_writer_unit u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_func     (in_func),
    .in_value    (in_value),
    .in_row      (in_row),
    .in_col      (in_col),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_pin_rs  (out_pin_rs),
    .out_pin_rw  (out_pin_rw),
    .out_pin_e   (out_pin_e),
    .out_nibble  (out_nibble),
    .out_hold_us (out_hold_us),
    .out_last    (out_last),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata)
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------- expansion
  function automatic void push_pin_step(logic rs, logic e, logic [3:0] nib,
                                        logic [15:0] hold);
    lcdnw_pkg::step_t s;
    s.pin_rs  = rs;
    s.pin_rw  = 1'b0;
    s.pin_e   = e;
    s.nibble  = nib;
    s.hold_us = hold;
    s.last    = 1'b0;
    pending_steps.push_back(s);
  endfunction

  // set, strobe, then release with the trailing wait
  function automatic void push_nibble(logic rs, logic [3:0] nib, logic [15:0] after);
    push_pin_step(rs, 1'b0, nib, 16'd0);
    push_pin_step(rs, 1'b1, nib, {8'd0, strobe_us});
    push_pin_step(rs, 1'b0, 4'h0, after);
  endfunction

  function automatic void push_byte(logic rs, logic [7:0] b);
    push_nibble(rs, b[7:4], {8'd0, settle_us});
    push_nibble(rs, b[3:0], {8'd0, settle_us});
  endfunction

  function automatic void expand_request(lcd_request_t r);
    int         first;
    logic [7:0] addr;
    logic [7:0] ch;
    first = pending_steps.size();
    addr  = lcdnw_pkg::ADDR_BASE + {2'b00, r.col}
          + (r.row ? lcdnw_pkg::ROW1_OFFSET : 8'h00);
    ch    = (r.value >= 8'd192) ? CYR_GLYPH[r.value - 8'd192] : r.value;
    case (r.func)
      lcdnw_pkg::FUNC_INIT: begin
        push_pin_step(1'b0, 1'b0, 4'h0, powerup_us);
        for (int i = 0; i < 9; i++) push_nibble(1'b0, PWRUP_NIB[i], PWRUP_WAIT[i]);
      end
      lcdnw_pkg::FUNC_CMD:  push_byte(1'b0, r.value);
      lcdnw_pkg::FUNC_DATA: push_byte(1'b1, r.value);
      // code zero marks end of string and sends nothing
      lcdnw_pkg::FUNC_TEXT: if (r.value != 8'd0) push_byte(1'b1, ch);
      lcdnw_pkg::FUNC_GOTO: push_byte(1'b0, addr);
      lcdnw_pkg::FUNC_CLEAR: begin
        push_byte(1'b0, addr);
        push_byte(1'b1, lcdnw_pkg::SPACE_CHAR);
      end
      default: ;
    endcase
    if (pending_steps.size() > first)
      pending_steps[pending_steps.size() - 1].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------- driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid  <= 1'b0;
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
      // hold a beat until taken, then offer the next one or idle
      if (!in_valid || req_taken) begin
        if (request_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
          next_req = request_q.pop_front();
          in_valid <= 1'b1;
          in_func  <= next_req.func;
          in_value <= next_req.value;
          in_row   <= next_req.row;
          in_col   <= next_req.col;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor
  always @(posedge clk) begin
    lcdnw_pkg::step_t got;
    lcdnw_pkg::step_t want;
    req_taken = rst_n && in_valid && !in_stall;
    if (req_taken)
      expand_request('{func: in_func, value: in_value, row: in_row, col: in_col});
    if (rst_n && out_valid && !out_stall) begin
      got = '{pin_rs: out_pin_rs, pin_rw: out_pin_rw, pin_e: out_pin_e,
              nibble: out_nibble, hold_us: out_hold_us, last: out_last};
      if (pending_steps.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10)
          $display("unexpected step: rs %b rw %b e %b nib %h hold %0d last %b",
                   got.pin_rs, got.pin_rw, got.pin_e, got.nibble, got.hold_us, got.last);
      end else begin
        want = pending_steps.pop_front();
        if (got.pin_rs !== want.pin_rs || got.pin_rw !== want.pin_rw ||
            got.pin_e !== want.pin_e || got.nibble !== want.nibble ||
            got.hold_us !== want.hold_us || got.last !== want.last) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("step mismatch: exp rs %b rw %b e %b nib %h hold %0d last %b",
                     want.pin_rs, want.pin_rw, want.pin_e, want.nibble,
                     want.hold_us, want.last,
                     " / got rs %b rw %b e %b nib %h hold %0d last %b",
                     got.pin_rs, got.pin_rw, got.pin_e, got.nibble,
                     got.hold_us, got.last);
        end
      end
    end
  end

  // ---------------------------------------------------------------- stimulus
  task automatic write_reg(logic [1:0] idx, logic [15:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      lcdnw_pkg::CFG_STROBE:  strobe_us  = data[7:0];
      lcdnw_pkg::CFG_SETTLE:  settle_us  = data[7:0];
      lcdnw_pkg::CFG_POWERUP: powerup_us = data;
      default: ;
    endcase
  endtask

  task automatic set_timing(logic [7:0] strobe, logic [7:0] settle, logic [15:0] pwr);
    write_reg(lcdnw_pkg::CFG_STROBE, {8'd0, strobe});
    write_reg(lcdnw_pkg::CFG_SETTLE, {8'd0, settle});
    write_reg(lcdnw_pkg::CFG_POWERUP, pwr);
  endtask

  function automatic void add_req(logic [2:0] f, logic [7:0] v, logic r, logic [5:0] c);
    request_q.push_back('{func: f, value: v, row: r, col: c});
  endfunction

  // mostly well-formed requests, some ignored codes mixed in
  function automatic void add_random_requests(int n_busy);
    lcd_request_t r;
    int           busy;
    int           pick;
    busy = 0;
    while (busy < n_busy) begin
      r.value = 8'($urandom_range(0, 255));
      r.row   = 1'($urandom_range(0, 1));
      r.col   = 6'($urandom_range(0, 63));
      pick    = $urandom_range(0, 99);
      if (pick < 5)       r.func = lcdnw_pkg::FUNC_INIT;
      else if (pick < 20) r.func = lcdnw_pkg::FUNC_CMD;
      else if (pick < 35) r.func = lcdnw_pkg::FUNC_DATA;
      else if (pick < 62) begin
        r.func = lcdnw_pkg::FUNC_TEXT;
        pick = $urandom_range(0, 9);
        if (pick == 0)     r.value = 8'd0;
        else if (pick < 6) r.value = 8'(192 + $urandom_range(0, 63));
      end
      else if (pick < 78) r.func = lcdnw_pkg::FUNC_GOTO;
      else if (pick < 92) r.func = lcdnw_pkg::FUNC_CLEAR;
      else if (pick < 96) r.func = $urandom_range(0, 1) ? FUNC_SPARE7 : FUNC_SPARE6;
      else begin
        r.func  = lcdnw_pkg::FUNC_TEXT;
        r.value = 8'd0;
      end
      if (r.func <= lcdnw_pkg::FUNC_CLEAR &&
          !(r.func == lcdnw_pkg::FUNC_TEXT && r.value == 8'd0)) busy++;
      request_q.push_back(r);
    end
  endfunction

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    for (int ph = 0; ph < 6; ph++) begin
      // receiver-heavy idling, then sender-heavy, then none
      if (ph < 2) begin
        tx_idle_pct = 38;
        rx_idle_pct = 76;
      end else if (ph < 4) begin
        tx_idle_pct = 76;
        rx_idle_pct = 38;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      case (ph)
        1: set_timing(8'd0, 8'd0, 16'd0);
        2: set_timing(8'd255, 8'd255, 16'd65535);
        3, 4: set_timing(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                         16'($urandom_range(0, 65535)));
        5: set_timing(8'd1, 8'd128, 16'd1);
        default: ;
      endcase
      if (ph == 0) begin
        // directed: every request kind, field extremes, special codes
        add_req(lcdnw_pkg::FUNC_INIT,  8'h00, 1'b0, 6'd0);
        add_req(lcdnw_pkg::FUNC_CMD,   8'h00, 1'b0, 6'd0);
        add_req(lcdnw_pkg::FUNC_CMD,   8'hFF, 1'b1, 6'd63);
        add_req(lcdnw_pkg::FUNC_CMD,   8'h01, 1'b0, 6'd0);
        add_req(lcdnw_pkg::FUNC_DATA,  8'h00, 1'b0, 6'd0);
        add_req(lcdnw_pkg::FUNC_DATA,  8'hFF, 1'b1, 6'd63);
        add_req(lcdnw_pkg::FUNC_DATA,  8'hA5, 1'b0, 6'd21);
        add_req(lcdnw_pkg::FUNC_TEXT,  8'h00, 1'b0, 6'd0);
        add_req(lcdnw_pkg::FUNC_TEXT,  8'h01, 1'b0, 6'd0);
        add_req(lcdnw_pkg::FUNC_TEXT,  8'h41, 1'b0, 6'd0);
        add_req(lcdnw_pkg::FUNC_TEXT,  8'd191, 1'b0, 6'd0);
        add_req(lcdnw_pkg::FUNC_TEXT,  8'd192, 1'b1, 6'd42);
        add_req(lcdnw_pkg::FUNC_TEXT,  8'd255, 1'b0, 6'd0);
        add_req(lcdnw_pkg::FUNC_GOTO,  8'h00, 1'b0, 6'd0);
        add_req(lcdnw_pkg::FUNC_GOTO,  8'hFF, 1'b1, 6'd63);
        add_req(lcdnw_pkg::FUNC_CLEAR, 8'h00, 1'b0, 6'd63);
        add_req(lcdnw_pkg::FUNC_CLEAR, 8'h00, 1'b1, 6'd0);
        add_req(FUNC_SPARE6,           8'hFF, 1'b1, 6'd63);
        add_req(FUNC_SPARE7,           8'h00, 1'b0, 6'd0);
        add_req(lcdnw_pkg::FUNC_INIT,  8'hFF, 1'b1, 6'd63);
      end else begin
        add_random_requests(BUSY_PER_PHASE);
      end
      // drain before touching the registers again
      while (request_q.size() != 0 || in_valid || pending_steps.size() != 0)
        @(posedge clk);
      repeat (DRAIN_CYCLES) @(posedge clk);
    end
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

### files.f
rtl/core/lcdnw_pkg.sv
rtl/core/lcdnw_front.sv
rtl/core/lcdnw_fifo.sv
rtl/core/lcdnw_back.sv
rtl/core/char_lcd_nibble_writer_unit.sv
tb/char_lcd_nibble_writer_unit_tb.sv
